@@ hw/rtl/fsd_pkg.sv @@
// Shared constants, types and helper functions for the Floyd-Steinberg dither unit.
// No dependencies; the other files of the block, but for fsd_ram, refer to this package by scoped names.
`default_nettype none

package fsd_pkg;

    localparam int MAX_COLUMNS = 2048;
    localparam int ERROR_BITS  = 12;
    localparam int COL_BITS    = $clog2(MAX_COLUMNS);
    // error times 7 before the shift needs five bits above the stored error
    localparam int WIDE_W      = ERROR_BITS + 5;

    localparam int PIXEL_W   = 8;
    localparam int CFG_COL_W = 12;
    localparam int CFG_ROW_W = 16;
    localparam int CMP_W     = (COL_BITS + 1 > CFG_COL_W) ? COL_BITS + 1 : CFG_COL_W;

    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 3;

    localparam logic [CFG_COL_W-1:0] COLUMNS_RESET = CFG_COL_W'(640);
    localparam logic [CFG_ROW_W-1:0] ROWS_RESET    = CFG_ROW_W'(480);

    // register index, taken from paddr[2]
    localparam logic REG_COLUMNS = 1'b0;
    localparam logic REG_ROWS    = 1'b1;

    localparam logic [PIXEL_W-1:0] LEVEL_WHITE = 8'hFF;
    localparam logic [PIXEL_W-1:0] LEVEL_BLACK = 8'h00;
    localparam int THRESHOLD = 128;

    localparam int ERR_MAX = (1 << (ERROR_BITS - 1)) - 1;
    localparam int ERR_MIN = -ERR_MAX - 1;

    typedef logic signed [ERROR_BITS-1:0] t_err;
    typedef logic signed [WIDE_W-1:0]     t_wide;

    typedef struct packed {
        logic [COL_BITS-1:0] col;
        logic                last_col;
        logic                last_row;
        logic                first_row;
    } t_pos;

    typedef struct packed {
        logic [PIXEL_W-1:0] gray;
        t_pos               pos;
    } t_item;

    function automatic t_wide widen(input t_err e);
        return {{(WIDE_W - ERROR_BITS){e[ERROR_BITS-1]}}, e};
    endfunction

    function automatic t_wide pixel_wide(input logic [PIXEL_W-1:0] p);
        return $signed({{(WIDE_W - PIXEL_W){1'b0}}, p});
    endfunction

    function automatic t_err sat_err(input t_wide v);
        if (v > t_wide'(ERR_MAX)) begin
            return t_err'(ERR_MAX);
        end else if (v < t_wide'(ERR_MIN)) begin
            return t_err'(ERR_MIN);
        end
        return $signed(v[ERROR_BITS-1:0]);
    endfunction

    // floor division by 16
    function automatic t_wide share16(input t_wide v);
        return v >>> 4;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/fsd_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module fsd_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ hw/rtl/fsd_scan.sv @@
// Column and row position tracking for the raster scan, sized from the configured image.
// Depends on fsd_pkg.
`default_nettype none

module fsd_scan (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_advance,
    input  wire logic [fsd_pkg::CFG_COL_W-1:0]  i_columns,
    input  wire logic [fsd_pkg::CFG_ROW_W-1:0]  i_rows,
    output fsd_pkg::t_pos                       o_pos
);

    logic [fsd_pkg::COL_BITS-1:0]  r_col;
    logic [fsd_pkg::CFG_ROW_W-1:0] r_row;

    logic [fsd_pkg::CMP_W-1:0]     cols_cfg;
    logic [fsd_pkg::CMP_W-1:0]     cols_eff;
    logic [fsd_pkg::CFG_ROW_W-1:0] rows_eff;
    logic                          last_col;
    logic                          last_row;

    always_comb begin
        cols_cfg = fsd_pkg::CMP_W'(i_columns);
        if (cols_cfg == '0) begin
            cols_eff = fsd_pkg::CMP_W'(1);
        end else if (cols_cfg > fsd_pkg::CMP_W'(fsd_pkg::MAX_COLUMNS)) begin
            cols_eff = fsd_pkg::CMP_W'(fsd_pkg::MAX_COLUMNS);
        end else begin
            cols_eff = cols_cfg;
        end
        rows_eff = (i_rows == '0) ? fsd_pkg::CFG_ROW_W'(1) : i_rows;

        // a count at or past the size closes its row or frame
        last_col = (fsd_pkg::CMP_W'(r_col) + fsd_pkg::CMP_W'(1)) >= cols_eff;
        last_row = ({1'b0, r_row} + (fsd_pkg::CFG_ROW_W + 1)'(1)) >= {1'b0, rows_eff};
    end

    assign o_pos.col       = r_col;
    assign o_pos.last_col  = last_col;
    assign o_pos.last_row  = last_row;
    assign o_pos.first_row = (r_row == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_advance) begin
            if (last_col) begin
                r_col <= '0;
                r_row <= last_row ? '0 : r_row + fsd_pkg::CFG_ROW_W'(1);
            end else begin
                r_col <= r_col + fsd_pkg::COL_BITS'(1);
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/fsd_diffuse.sv @@
// Threshold and error diffusion for one pixel, carry registers and the next-row error line.
// Depends on fsd_pkg and fsd_ram.
`default_nettype none

module fsd_diffuse (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire fsd_pkg::t_item                i_item,
    input  wire logic                          i_fire,
    input  wire logic                          i_accept,
    input  wire logic [fsd_pkg::COL_BITS-1:0]  i_read_col,
    output logic      [fsd_pkg::PIXEL_W-1:0]   o_level,
    output logic                               o_frame_end
);

    fsd_pkg::t_err r_carry;
    fsd_pkg::t_err r_below_left;
    fsd_pkg::t_err r_below_here;

    // end-of-row line write, done on the cycle after the last column
    logic                         r_dw_valid;
    logic [fsd_pkg::COL_BITS-1:0] r_dw_col;
    fsd_pkg::t_err                r_dw_data;

    // line writes that landed after the read for the held pixel was issued
    logic          r_fwd_valid;
    fsd_pkg::t_err r_fwd_data;

    logic [fsd_pkg::ERROR_BITS-1:0] ram_rdata;
    fsd_pkg::t_err                  line_err;
    fsd_pkg::t_wide                 work;
    fsd_pkg::t_wide                 err;
    fsd_pkg::t_wide                 s1;
    fsd_pkg::t_wide                 s3;
    fsd_pkg::t_wide                 s5;
    fsd_pkg::t_wide                 s7;
    logic                           is_white;
    fsd_pkg::t_err                  n_below_left;
    fsd_pkg::t_err                  imm_data;

    logic                         wr_en;
    logic [fsd_pkg::COL_BITS-1:0] wr_col;
    fsd_pkg::t_err                wr_data;
    logic [fsd_pkg::COL_BITS-1:0] n_watch_col;

    fsd_ram #(
        .WIDTH (fsd_pkg::ERROR_BITS),
        .DEPTH (fsd_pkg::MAX_COLUMNS)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_col),
        .i_wdata (wr_data),
        .i_re    (i_accept),
        .i_raddr (i_read_col),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        if (r_dw_valid && (r_dw_col == i_item.pos.col)) begin
            line_err = r_dw_data;
        end else if (r_fwd_valid) begin
            line_err = r_fwd_data;
        end else begin
            line_err = $signed(ram_rdata);
        end

        work = fsd_pkg::pixel_wide(i_item.gray) + fsd_pkg::widen(r_carry);
        if (!i_item.pos.first_row) begin
            work = work + fsd_pkg::widen(line_err);
        end

        is_white = work > fsd_pkg::t_wide'(fsd_pkg::THRESHOLD);
        err      = work - (is_white ? fsd_pkg::pixel_wide(fsd_pkg::LEVEL_WHITE) : '0);

        s7 = fsd_pkg::share16((err <<< 3) - err);
        s5 = fsd_pkg::share16((err <<< 2) + err);
        s3 = fsd_pkg::share16((err <<< 1) + err);
        s1 = fsd_pkg::share16(err);

        imm_data     = fsd_pkg::sat_err(fsd_pkg::widen(r_below_left) + s3);
        n_below_left = fsd_pkg::sat_err(fsd_pkg::widen(r_below_here) + s5);

        // after a last column the next pixel is column 0, so the port is free
        wr_en   = (i_fire && (i_item.pos.col != '0)) || r_dw_valid;
        wr_col  = r_dw_valid ? r_dw_col : i_item.pos.col - fsd_pkg::COL_BITS'(1);
        wr_data = r_dw_valid ? r_dw_data : imm_data;

        n_watch_col = i_accept ? i_read_col : i_item.pos.col;
    end

    assign o_level     = is_white ? fsd_pkg::LEVEL_WHITE : fsd_pkg::LEVEL_BLACK;
    assign o_frame_end = i_item.pos.last_col && i_item.pos.last_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carry      <= '0;
            r_below_left <= '0;
            r_below_here <= '0;
            r_dw_valid   <= 1'b0;
            r_fwd_valid  <= 1'b0;
        end else begin
            r_dw_valid <= i_fire && i_item.pos.last_col;
            if (i_fire) begin
                if (i_item.pos.last_col) begin
                    r_carry      <= '0;
                    r_below_left <= '0;
                    r_below_here <= '0;
                end else begin
                    r_carry      <= fsd_pkg::sat_err(s7);
                    r_below_left <= n_below_left;
                    r_below_here <= fsd_pkg::sat_err(s1);
                end
            end
            if (wr_en && (wr_col == n_watch_col)) begin
                r_fwd_valid <= 1'b1;
            end else if (i_accept) begin
                r_fwd_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && i_item.pos.last_col) begin
            r_dw_col  <= i_item.pos.col;
            r_dw_data <= n_below_left;
        end
        if (wr_en && (wr_col == n_watch_col)) begin
            r_fwd_data <= wr_data;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/floyd_steinberg_dither_unit.sv @@
// Top level of the Floyd-Steinberg dither unit: APB registers, input and result registers.
// Depends on fsd_pkg, fsd_scan and fsd_diffuse.
`default_nettype none

// Takes one 8-bit grayscale pixel per clock in raster order and returns one pixel of 0 or
// 255 per input, with tlast high on the last pixel of each frame. Throughput is one pixel
// per cycle, with no gaps at row or frame boundaries, while m_axis_tready does not stall the
// output; each result passes the input register, then the result register. The
// one-pixel-per-cycle rate is set by the right-carry loop: sum, threshold, times-7 share
// and saturation are combinational between the input register and the carry register.
// Errors for the next row sit in a 2048-entry line RAM; row 0 of a frame ignores it, so
// no clearing pass is needed after reset. Write image_columns (0x0) and image_rows (0x4)
// only while no pixel is in flight.
module floyd_steinberg_dither_unit (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // pixel input
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [7:0]                     s_axis_tdata,   // [7:0] gray_level
    // dithered output
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic      [7:0]                     m_axis_tdata,   // [7:0] out_level
    output logic                                m_axis_tlast,   // frame_end
    // configuration
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [fsd_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [fsd_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [fsd_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready
);

    logic [fsd_pkg::CFG_COL_W-1:0] r_columns;
    logic [fsd_pkg::CFG_ROW_W-1:0] r_rows;

    logic           r_s1_valid;
    fsd_pkg::t_item r_s1_item;

    logic                        r_out_valid;
    logic [fsd_pkg::PIXEL_W-1:0] r_out_level;
    logic                        r_out_last;

    logic                        accept;
    logic                        s1_fire;
    logic                        cfg_write;
    fsd_pkg::t_pos               scan_pos;
    logic [fsd_pkg::PIXEL_W-1:0] level;
    logic                        frame_end;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb begin
        case (paddr[2])
            fsd_pkg::REG_COLUMNS: prdata = fsd_pkg::APB_DATA_W'(r_columns);
            fsd_pkg::REG_ROWS:    prdata = fsd_pkg::APB_DATA_W'(r_rows);
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns <= fsd_pkg::COLUMNS_RESET;
            r_rows    <= fsd_pkg::ROWS_RESET;
        end else if (cfg_write) begin
            case (paddr[2])
                fsd_pkg::REG_COLUMNS: r_columns <= pwdata[fsd_pkg::CFG_COL_W-1:0];
                fsd_pkg::REG_ROWS:    r_rows    <= pwdata[fsd_pkg::CFG_ROW_W-1:0];
                default:              r_rows    <= r_rows;
            endcase
        end
    end

    // advance the compute stage whenever the result register is free or draining
    assign s1_fire       = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_fire;
    assign accept        = s_axis_tvalid && s_axis_tready;

    fsd_scan u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (accept),
        .i_columns (r_columns),
        .i_rows    (r_rows),
        .o_pos     (scan_pos)
    );

    fsd_diffuse u_diffuse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (r_s1_item),
        .i_fire      (s1_fire),
        .i_accept    (accept),
        .i_read_col  (scan_pos.col),
        .o_level     (level),
        .o_frame_end (frame_end)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_item.gray <= s_axis_tdata;
            r_s1_item.pos  <= scan_pos;
        end
        if (s1_fire) begin
            r_out_level <= level;
            r_out_last  <= frame_end;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_level;
    assign m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

@@ hw/rtl/fsd_checker.sv @@
// Port-level assertions for the Floyd-Steinberg dither unit, bound to the top level.
// Depends on fsd_pkg and floyd_steinberg_dither_unit.
`default_nettype none

module fsd_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           s_axis_tready,
    input wire logic                           m_axis_tvalid,
    input wire logic                           m_axis_tready,
    input wire logic [7:0]                     m_axis_tdata,
    input wire logic                           m_axis_tlast,
    input wire logic                           psel,
    input wire logic                           penable,
    input wire logic                           pwrite,
    input wire logic [fsd_pkg::PADDR_W-1:0]    paddr,
    input wire logic [fsd_pkg::APB_DATA_W-1:0] pwdata,
    input wire logic [fsd_pkg::APB_DATA_W-1:0] prdata,
    input wire logic                           pready
);

    // results are binary
    a_level_binary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata == fsd_pkg::LEVEL_WHITE ||
                           m_axis_tdata == fsd_pkg::LEVEL_BLACK))
        else $error("dithered level is neither black nor white");

    // an empty result register never stalls the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while no result is pending");

    // a row-count write reads back on the next cycle
    a_rows_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(psel && penable && pwrite && pready) &&
         $past(paddr[2]) == fsd_pkg::REG_ROWS && paddr[2] == fsd_pkg::REG_ROWS)
        |-> prdata[fsd_pkg::CFG_ROW_W-1:0] == $past(pwdata[fsd_pkg::CFG_ROW_W-1:0]))
        else $error("rows register does not read back the value written");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("stalled result changed");

endmodule

bind floyd_steinberg_dither_unit fsd_checker u_fsd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
);

`default_nettype wire

@@ bench/tb_floyd_steinberg_dither_unit.sv @@
// Self-checking bench for floyd_steinberg_dither_unit: streams gray pixel words, writes the
// size registers over APB and compares each dithered word against an in-bench diffusion model.
// Depends on fsd_pkg and the dither unit RTL.
module tb_floyd_steinberg_dither_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT    = 2000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int RANDOM_PIXELS = 460;
    localparam int WIDE_PIXELS   = 60;
    localparam int PRINT_CAP     = 40;

    typedef struct {
        logic [7:0] level;
        logic       frame_end;
    } t_dither_word;

    typedef enum int {TONE_NOISE, TONE_FLAT, TONE_EDGES} t_tone;

    class dither_checker;
        int           next_row_err [fsd_pkg::MAX_COLUMNS];
        bit           row_err_seen [fsd_pkg::MAX_COLUMNS];
        int           right_err;
        int           below_left_err;
        int           below_here_err;
        int unsigned  col_pos;
        int unsigned  row_pos;
        logic [11:0]  columns_reg;
        logic [15:0]  rows_reg;
        t_dither_word due_words[$];
        int           errors;
        int           checked;

        function new();
            foreach (next_row_err[i]) begin
                next_row_err[i] = 0;
                row_err_seen[i] = 1'b0;
            end
            right_err      = 0;
            below_left_err = 0;
            below_here_err = 0;
            col_pos        = 0;
            row_pos        = 0;
            columns_reg    = fsd_pkg::COLUMNS_RESET;
            rows_reg       = fsd_pkg::ROWS_RESET;
            errors         = 0;
            checked        = 0;
        endfunction

        function void write_reg(logic idx, logic [31:0] value);
            if (idx == fsd_pkg::REG_COLUMNS) begin
                columns_reg = value[11:0];
            end else begin
                rows_reg = value[15:0];
            end
        endfunction

        function int unsigned width_of(logic [11:0] v);
            if (v == 0) return 1;
            if (v > fsd_pkg::MAX_COLUMNS) return fsd_pkg::MAX_COLUMNS;
            return v;
        endfunction

        // a wider row must only read line entries that some earlier row has written
        function bit width_ok(logic [11:0] v);
            int unsigned w;
            w = width_of(v);
            if (row_pos == 0 || w <= width_of(columns_reg)) return 1'b1;
            for (int i = 0; i < w; i++) begin
                if (!row_err_seen[i]) return 1'b0;
            end
            return 1'b1;
        endfunction

        function int floor16(int n);
            return n >>> 4;
        endfunction

        function int clip_err(int n);
            if (n > fsd_pkg::ERR_MAX) return fsd_pkg::ERR_MAX;
            if (n < fsd_pkg::ERR_MIN) return fsd_pkg::ERR_MIN;
            return n;
        endfunction

        function void diffuse_pixel(logic [7:0] gray);
            int unsigned  cols;
            int unsigned  rows;
            int unsigned  x;
            int           work;
            int           err;
            bit           end_col;
            bit           end_row;
            t_dither_word word;
            cols = width_of(columns_reg);
            rows = (rows_reg == 0) ? 1 : rows_reg;
            x = (col_pos >= fsd_pkg::MAX_COLUMNS) ? fsd_pkg::MAX_COLUMNS - 1 : col_pos;
            end_col = (x + 1 >= cols);
            end_row = (row_pos + 1 >= rows);

            work = int'(gray) + right_err;
            if (row_pos != 0) work += next_row_err[x];
            word.level = (work > fsd_pkg::THRESHOLD) ? fsd_pkg::LEVEL_WHITE : fsd_pkg::LEVEL_BLACK;
            word.frame_end = end_col && end_row;
            err = work - int'(word.level);

            right_err = end_col ? 0 : clip_err(floor16(err * 7));
            if (x > 0) begin
                next_row_err[x-1] = clip_err(below_left_err + floor16(err * 3));
                row_err_seen[x-1] = 1'b1;
            end
            below_left_err = clip_err(below_here_err + floor16(err * 5));
            below_here_err = end_col ? 0 : clip_err(floor16(err));
            due_words.push_back(word);

            if (end_col) begin
                next_row_err[x] = below_left_err;
                row_err_seen[x] = 1'b1;
                below_left_err  = 0;
                below_here_err  = 0;
                right_err       = 0;
                col_pos         = 0;
                row_pos         = end_row ? 0 : row_pos + 1;
            end else begin
                col_pos = x + 1;
            end
        endfunction

        task flag_mismatch(string what);
            errors++;
            if (errors <= PRINT_CAP) $display("mismatch at output word %0d: %s", checked, what);
        endtask

        task match_output(logic [7:0] level, logic frame_end);
            t_dither_word want;
            checked++;
            if (due_words.size() == 0) begin
                flag_mismatch("output word with no pixel pending");
                return;
            end
            want = due_words.pop_front();
            if (level !== want.level) begin
                flag_mismatch($sformatf("level %0d, expected %0d", level, want.level));
            end
            if (frame_end !== want.frame_end) begin
                flag_mismatch($sformatf("tlast %b, expected %b", frame_end, want.frame_end));
            end
        endtask

        function int pending();
            return due_words.size();
        endfunction
    endclass

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              s_axis_tvalid;
    logic                              s_axis_tready;
    logic [7:0]                        s_axis_tdata;    // [7:0] gray_level
    logic                              m_axis_tvalid;
    logic                              m_axis_tready;
    logic [7:0]                        m_axis_tdata;    // [7:0] out_level
    logic                              m_axis_tlast;
    logic                              psel;
    logic                              penable;
    logic                              pwrite;
    logic [fsd_pkg::PADDR_W-1:0]       paddr;
    logic [fsd_pkg::APB_DATA_W-1:0]    pwdata;
    logic [fsd_pkg::APB_DATA_W-1:0]    prdata;
    logic                              pready;

    dither_checker board = new();
    bit            steady = 1'b0;
    int            random_sent = 0;

    floyd_steinberg_dither_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("tb_floyd_steinberg_dither_unit: errors");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            board.match_output(m_axis_tdata, m_axis_tlast);
        end
    end

    function automatic int draw_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // output stall: stalls drawn from the same gap mix as the input, short random ready bursts
    initial begin : output_stall
        int hold;
        m_axis_tready = 1'b0;
        hold = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (steady) begin
                m_axis_tready = 1'b1;
                hold = 0;
            end else if (hold > 0) begin
                hold--;
            end else if (m_axis_tready) begin
                hold = draw_gap();
                if (hold > 0) begin
                    m_axis_tready = 1'b0;
                    hold--;
                end else begin
                    hold = $urandom_range(0, 6);
                end
            end else begin
                m_axis_tready = 1'b1;
                hold = $urandom_range(0, 8);
            end
        end
    end

    // called at a falling edge; returns at the falling edge after the word is taken
    task automatic send_pixel(input logic [7:0] level);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = level;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        board.diffuse_pixel(level);
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (board.pending() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        board.write_reg(idx, value);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    function automatic logic [7:0] draw_level(input t_tone tone, input int base);
        int v;
        case (tone)
            TONE_FLAT: begin
                v = base + $urandom_range(0, 8) - 4;
                if (v < 0) v = 0;
                if (v > 255) v = 255;
                return v[7:0];
            end
            TONE_EDGES: begin
                case ($urandom_range(0, 4))
                    0: return 8'd0;
                    1: return 8'd255;
                    2: return 8'd128;
                    3: return 8'd129;
                    default: return 8'd127;
                endcase
            end
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic random_phase(input bit force_pause);
        logic [11:0] cols;
        logic [15:0] rows;
        int          r;
        int          count;
        int          pause_at;
        int          base;
        t_tone       tone;
        r = $urandom_range(0, 99);
        if (r < 8) cols = 12'd0;
        else if (r < 70) cols = 12'($urandom_range(1, 8));
        else if (r < 95) cols = 12'($urandom_range(9, 32));
        else cols = 12'($urandom_range(33, 100));
        r = $urandom_range(0, 99);
        if (r < 8) rows = 16'd0;
        else if (r < 80) rows = 16'($urandom_range(1, 6));
        else if (r < 95) rows = 16'($urandom_range(7, 20));
        else rows = 16'hFFFF;

        // most phases resize between words, often mid-frame
        if ($urandom_range(0, 3) != 0) begin
            drain();
            if ($urandom_range(0, 3) != 0 && board.width_ok(cols)) begin
                write_reg(fsd_pkg::REG_COLUMNS, {20'd0, cols});
            end
            if ($urandom_range(0, 3) != 0) write_reg(fsd_pkg::REG_ROWS, {16'd0, rows});
        end

        steady = ($urandom_range(0, 4) == 0);
        r = $urandom_range(0, 9);
        tone = (r < 5) ? TONE_NOISE : (r < 8) ? TONE_FLAT : TONE_EDGES;
        base = $urandom_range(0, 255);
        count = $urandom_range(8, 40);
        pause_at = (force_pause || $urandom_range(0, 9) == 0) ? $urandom_range(1, count - 1) : -1;
        for (int i = 0; i < count; i++) begin
            if (i == pause_at) drain();
            send_pixel(draw_level(tone, base));
        end
        random_sent += count;
    endtask

    initial begin : stimulus
        logic [7:0] dark_row [7] = '{8'd0, 8'd255, 8'd128, 8'd129, 8'd127, 8'd1, 8'd254};
        logic [7:0] two_rows [6] = '{8'd200, 8'd255, 8'd255, 8'd1, 8'd254, 8'd128};
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'd0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset size, threshold neighbors and extremes on row 0
        foreach (dark_row[i]) send_pixel(dark_row[i]);
        // zero sizes act as 1x1, and shrink mid-row: each word closes a frame
        drain();
        write_reg(fsd_pkg::REG_COLUMNS, 32'd0);
        write_reg(fsd_pkg::REG_ROWS, 32'd0);
        send_pixel(8'd255);
        send_pixel(8'd0);
        send_pixel(8'd129);
        // only the low 12 bits of the width count
        drain();
        write_reg(fsd_pkg::REG_COLUMNS, 32'hABCD_E003);
        write_reg(fsd_pkg::REG_ROWS, 32'd2);
        foreach (two_rows[i]) send_pixel(two_rows[i]);
        // tallest frame, then cut it short while on row 2
        drain();
        write_reg(fsd_pkg::REG_ROWS, 32'd65535);
        write_reg(fsd_pkg::REG_COLUMNS, 32'd2);
        repeat (5) send_pixel(8'd128);
        drain();
        write_reg(fsd_pkg::REG_ROWS, 32'd1);
        send_pixel(8'd130);
        send_pixel(8'd126);

        // maximum width, then an oversized width that acts as the maximum, then a shrink
        // that closes the long row 0 at once
        drain();
        write_reg(fsd_pkg::REG_COLUMNS, 32'd2048);
        write_reg(fsd_pkg::REG_ROWS, 32'd2);
        repeat (WIDE_PIXELS) send_pixel(8'($urandom_range(0, 255)));
        drain();
        write_reg(fsd_pkg::REG_COLUMNS, 32'd4095);
        repeat (6) send_pixel(8'($urandom_range(0, 255)));
        drain();
        write_reg(fsd_pkg::REG_COLUMNS, 32'd6);
        send_pixel(8'($urandom_range(0, 255)));

        random_phase(1'b1);
        while (random_sent < RANDOM_PIXELS) random_phase(1'b0);

        drain();
        steady = 1'b0;
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (board.pending() != 0) board.flag_mismatch("pixels left without output word");
        if (board.errors == 0) begin
            $display("tb_floyd_steinberg_dither_unit: clean");
        end else begin
            $display("tb_floyd_steinberg_dither_unit: errors");
        end
        $finish;
    end

endmodule
